// ===== hw/rtl/pls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store: sizes, request
// kinds, beat structs and the memory port groups.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int DEPTH  = 1024;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 11;
   localparam int KIND_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_READ   = 3'd2,
      KIND_NEXT   = 3'd3,
      KIND_PREV   = 3'd4,
      KIND_LOCATE = 3'd5,
      KIND_CLEAR  = 3'd6
   } pls_kind_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  position;
      logic [31:0]       item_value;
   } pls_req_type;

   typedef struct packed {
      logic              ok;
      logic [31:0]       read_value;
      logic [POS_W-1:0]  found_position;
      logic [CNT_W-1:0]  entry_count;
   } pls_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } pls_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } pls_rd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pls_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pls_ram (
   input  wire                       clock,
   input  pls_pkg::pls_wr_type       wr,
   input  pls_pkg::pls_rd_type       rd,
   output logic [pls_pkg::DATA_W-1:0] rdata
);
   import pls_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata <= mem[rd.addr];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pls_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ctrl
// Request sequencer: decodes a request, walks the entry store one address a
// cycle (shift up, shift down, scan or single read) and forms the result.
// ----------------------------------------------------------------------------
module pls_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  pls_pkg::pls_req_type       req,
   output logic                       busy,
   output logic                       done,
   output pls_pkg::pls_rsp_type       result,
   output pls_pkg::pls_wr_type        wr,
   output pls_pkg::pls_rd_type        rd,
   input  wire [pls_pkg::DATA_W-1:0]  rdata
);
   import pls_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_FINAL = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] stop_ff, stop_in;
   logic              down_ff, down_in;
   logic              move_ff, move_in;
   logic              rvalid_ff, rvalid_in;
   logic              rmove_ff, rmove_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [CNT_W-1:0]  pos_c;
   logic [CNT_W-1:0]  pos_m1;
   logic [CNT_W-1:0]  pos_m2;
   logic [CNT_W-1:0]  cnt_p1;
   logic [CNT_W-1:0]  cnt_m1;
   logic              match;

   assign pos_c  = req.position;
   assign pos_m1 = pos_c - CNT_W'(1);
   assign pos_m2 = pos_c - CNT_W'(2);
   assign cnt_p1 = count_ff + CNT_W'(1);
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign match  = rvalid_ff && (rdata == val_ff);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      val_in    = val_ff;
      ptr_in    = ptr_ff;
      stop_in   = stop_ff;
      down_in   = down_ff;
      move_in   = move_ff;
      rvalid_in = 1'b0;
      rmove_in  = 1'b0;
      raddr_in  = raddr_ff;
      count_in  = count_ff;
      done      = 1'b0;
      result    = '0;
      rd        = '0;
      // write-back of the beat read last cycle, one place up or down
      wr.en     = rvalid_ff && rmove_ff;
      wr.addr   = down_ff ? raddr_ff + ADDR_W'(1) : raddr_ff - ADDR_W'(1);
      wr.data   = rdata;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req.kind;
               val_in  = req.item_value;
               move_in = 1'b0;
               down_in = 1'b0;
               case (req.kind)
                  KIND_INSERT: begin
                     if (pos_c != '0 && pos_c <= cnt_p1 && count_ff < CNT_W'(DEPTH)) begin
                        stop_in = pos_m1[ADDR_W-1:0];
                        if (pos_m1 == count_ff) begin
                           state_in = S_FINAL;
                        end else begin
                           ptr_in   = cnt_m1[ADDR_W-1:0];
                           down_in  = 1'b1;
                           move_in  = 1'b1;
                           state_in = S_WALK;
                        end
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (pos_c != '0 && pos_c <= count_ff) begin
                        if (pos_c == count_ff) begin
                           count_in  = cnt_m1;
                           done      = 1'b1;
                           result.ok = 1'b1;
                        end else begin
                           ptr_in   = pos_c[ADDR_W-1:0];
                           stop_in  = cnt_m1[ADDR_W-1:0];
                           move_in  = 1'b1;
                           state_in = S_WALK;
                        end
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_READ: begin
                     if (pos_c != '0 && pos_c <= count_ff) begin
                        ptr_in   = pos_m1[ADDR_W-1:0];
                        stop_in  = pos_m1[ADDR_W-1:0];
                        state_in = S_WALK;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_NEXT: begin
                     if (pos_c != '0 && pos_c < count_ff) begin
                        ptr_in   = pos_c[ADDR_W-1:0];
                        stop_in  = pos_c[ADDR_W-1:0];
                        state_in = S_WALK;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_PREV: begin
                     if (pos_c >= CNT_W'(2) && pos_c <= cnt_p1) begin
                        ptr_in   = pos_m2[ADDR_W-1:0];
                        stop_in  = pos_m2[ADDR_W-1:0];
                        state_in = S_WALK;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_LOCATE: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        stop_in  = cnt_m1[ADDR_W-1:0];
                        state_in = S_WALK;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in  = '0;
                     done      = 1'b1;
                     result.ok = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            rd.en     = 1'b1;
            rd.addr   = ptr_ff;
            rvalid_in = 1'b1;
            rmove_in  = move_ff;
            raddr_in  = ptr_ff;
            if (ptr_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = down_ff ? ptr_ff - ADDR_W'(1) : ptr_ff + ADDR_W'(1);
            end
            // first hit ends the scan; the read in flight is dropped
            if (kind_ff == KIND_LOCATE && match) begin
               done                  = 1'b1;
               result.ok             = 1'b1;
               result.found_position = POS_W'(raddr_ff) + POS_W'(1);
               state_in              = S_IDLE;
            end
         end
         S_DRAIN: begin
            case (kind_ff)
               KIND_INSERT: begin
                  state_in = S_FINAL;
               end
               KIND_REMOVE: begin
                  count_in  = cnt_m1;
                  done      = 1'b1;
                  result.ok = 1'b1;
                  state_in  = S_IDLE;
               end
               KIND_LOCATE: begin
                  done = 1'b1;
                  if (match) begin
                     result.ok             = 1'b1;
                     result.found_position = POS_W'(raddr_ff) + POS_W'(1);
                  end
                  state_in = S_IDLE;
               end
               default: begin
                  done              = 1'b1;
                  result.ok         = 1'b1;
                  result.read_value = 32'(rdata);
                  state_in          = S_IDLE;
               end
            endcase
         end
         S_FINAL: begin
            wr.en     = 1'b1;
            wr.addr   = stop_ff;
            wr.data   = val_ff;
            count_in  = cnt_p1;
            done      = 1'b1;
            result.ok = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      result.entry_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         rmove_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         rmove_ff  <= rmove_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      val_ff   <= val_in;
      ptr_ff   <= ptr_in;
      stop_ff  <= stop_in;
      down_ff  <= down_in;
      move_ff  <= move_in;
      raddr_ff <= raddr_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr.en)
      else $error("store written while idle");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == S_IDLE)
      else $error("result given but sequencer not back to idle");

   a_final_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> $past(state_ff) == S_DRAIN || $past(state_ff) == S_IDLE)
      else $error("insert write reached without draining the shift");

endmodule
`default_nettype wire

// ===== hw/rtl/positional_list_store_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of up to 1024 words addressed by 1-based position, held in a
// single-port-read, single-port-write synchronous store.
// ----------------------------------------------------------------------------
// Use: drive req_item and raise start; the beat is taken at an edge where
// busy is low. Each request gives exactly one result beat on rsp_item,
// marked by rsp_strobe for one cycle; the receiver cannot hold it off.
// Path from accept to strobe (states idle, walk, drain, final):
//   clear, failed checks, remove of the last entry: idle; append insert: final
//   read, next, previous: one walk read, then drain
//   insert at p: walk moves entries p..count up one, then drain, final
//   remove at p: p+1..count move down, drain; locate: walk to the first match
// The store serves one read and one write a cycle, so shifts and scans move
// one entry per cycle; a request is only taken once the previous one has
// finished, and busy may drop while its strobe is still showing.
// Reset empties the list at once; stored words are not cleared and are only
// ever read below the entry count.
// ----------------------------------------------------------------------------
module positional_list_store_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  pls_pkg::pls_req_type  req_item,
   output logic                  rsp_strobe,
   output pls_pkg::pls_rsp_type  rsp_item
);
   import pls_pkg::*;

   pls_wr_type        wr;
   pls_rd_type        rd;
   logic [DATA_W-1:0] rdata;
   logic              done;
   pls_rsp_type       result;

   logic              rsp_strobe_ff;
   pls_rsp_type       rsp_item_ff;

   pls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_item),
      .busy   (busy),
      .done   (done),
      .result (result),
      .wr     (wr),
      .rd     (rd),
      .rdata  (rdata)
   );

   pls_ram u_ram (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   // result register: one beat per request, shown for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_store_core. A queue of requests,
// filled up front, feeds a bursty driver; each accepted beat is run through
// a local list predictor and the expected reply is queued. The monitor takes
// every strobed reply and checks it field by field against the oldest one.
// Stimulus: a short directed run over the edge cases, random traffic on a
// small list, a fill to a long list with work at its ends, then more
// random traffic.
// ----------------------------------------------------------------------------
module testbench;
   import pls_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam int                FILL_COUNT  = 256;

   typedef struct {
      pls_req_type req;
      bit          drain;   // hold this beat back until all replies are in
   } list_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   pls_req_type req_item = '0;
   logic        rsp_strobe;
   pls_rsp_type rsp_item;

   positional_list_store_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [31:0] list_words [DEPTH];
   int          list_count = 0;

   // stimulus planning state
   int          plan_count = 0;
   logic [31:0] value_pool [8];

   list_request_type list_requests [$];
   pls_rsp_type      expected_replies [$];
   int               fail_count = 0;

   // driver state
   bit          took;
   bit          present;
   int          burst_left = 0;
   int          gap_left = 0;
   pls_rsp_type want;

   function automatic pls_rsp_type apply_request(input pls_req_type r);
      pls_rsp_type res;
      int          p;
      int          i;
      res = '0;
      p = int'(r.position);
      case (r.kind)
         KIND_INSERT: if (p >= 1 && p <= list_count + 1 && list_count < DEPTH) begin
            for (i = list_count; i >= p; i--)
               list_words[i] = list_words[i-1];
            list_words[p-1] = r.item_value;
            list_count++;
            res.ok = 1'b1;
         end
         KIND_REMOVE: if (p >= 1 && p <= list_count) begin
            for (i = p; i < list_count; i++)
               list_words[i-1] = list_words[i];
            list_count--;
            res.ok = 1'b1;
         end
         KIND_READ: if (p >= 1 && p <= list_count) begin
            res.read_value = list_words[p-1];
            res.ok = 1'b1;
         end
         KIND_NEXT: if (p >= 1 && p < list_count) begin
            res.read_value = list_words[p];
            res.ok = 1'b1;
         end
         KIND_PREV: if (p >= 2 && p <= list_count + 1) begin
            res.read_value = list_words[p-2];
            res.ok = 1'b1;
         end
         KIND_LOCATE: begin
            for (i = 0; i < list_count && !res.ok; i++) begin
               if (list_words[i] == r.item_value) begin
                  res.found_position = POS_W'(i + 1);
                  res.ok = 1'b1;
               end
            end
         end
         KIND_CLEAR: begin
            list_count = 0;
            res.ok = 1'b1;
         end
         default: ;
      endcase
      res.entry_count = CNT_W'(list_count);
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp_val);
      fail_count++;
      if (fail_count <= 40)
         $display("tb: mismatch on %s at %0t: got %0h, want %0h",
                  what, $time, got, exp_val);
   endtask

   // queues one request and tracks the entry count it leaves behind
   task automatic queue_request(input logic [KIND_W-1:0] kind, input int pos,
                                input logic [31:0] value, input bit drain = 1'b0);
      list_request_type slot;
      slot.req.kind       = kind;
      slot.req.position   = POS_W'(pos);
      slot.req.item_value = value;
      slot.drain          = drain;
      list_requests.push_back(slot);
      case (kind)
         KIND_INSERT:
            if (pos >= 1 && pos <= plan_count + 1 && plan_count < DEPTH) plan_count++;
         KIND_REMOVE:
            if (pos >= 1 && pos <= plan_count) plan_count--;
         KIND_CLEAR:
            plan_count = 0;
         default: ;
      endcase
   endtask

   // mostly well-formed requests around the current size; a little noise
   task automatic queue_random(input int cap);
      int               w;
      int               pos;
      logic [KIND_W-1:0] kind;
      logic [31:0]      value;
      w = $urandom_range(0, 99);
      if (w < 5) begin
         queue_request(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 2047), $urandom);
      end else begin
         w = $urandom_range(0, 99);
         if (w < (plan_count < cap ? 35 : 10)) kind = KIND_INSERT;
         else if (w < 55) kind = KIND_REMOVE;
         else if (w < 67) kind = KIND_READ;
         else if (w < 77) kind = KIND_NEXT;
         else if (w < 87) kind = KIND_PREV;
         else if (w < 98) kind = KIND_LOCATE;
         else kind = KIND_CLEAR;
         case ($urandom_range(0, 9))
            0:       pos = 0;
            1:       pos = plan_count + 1;
            2:       pos = plan_count + 2;
            3:       pos = plan_count;
            default: pos = $urandom_range(1, plan_count + 1);
         endcase
         value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
         queue_request(kind, pos, value, $urandom_range(0, 49) == 0);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         took = start && !busy;
         if (took) expected_replies.push_back(apply_request(req_item));
         present = start && !took;
         if (!present) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (list_requests.size() > 0 &&
                         !(list_requests[0].drain && expected_replies.size() > 0)) begin
               req_item <= list_requests[0].req;
               list_requests.pop_front();
               present = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         start <= present;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            note_mismatch("reply with nothing outstanding",
                          32'(rsp_item.entry_count), 32'h0);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_item.ok !== want.ok)
               note_mismatch("ok", 32'(rsp_item.ok), 32'(want.ok));
            if (rsp_item.read_value !== want.read_value)
               note_mismatch("read_value", rsp_item.read_value, want.read_value);
            if (rsp_item.found_position !== want.found_position)
               note_mismatch("found_position", 32'(rsp_item.found_position),
                             32'(want.found_position));
            if (rsp_item.entry_count !== want.entry_count)
               note_mismatch("entry_count", 32'(rsp_item.entry_count),
                             32'(want.entry_count));
         end
      end
   end

   initial begin
      logic [31:0] last_fill;
      int          n;
      value_pool[0] = 32'h0;
      value_pool[1] = 32'hFFFF_FFFF;
      for (n = 2; n < 8; n++) value_pool[n] = $urandom;

      // directed: empty list, bad positions, small list edges
      queue_request(KIND_READ,   1, 32'h0);
      queue_request(KIND_REMOVE, 1, 32'h0);
      queue_request(KIND_PREV,   1, 32'h0);
      queue_request(KIND_LOCATE, 0, 32'h0);
      queue_request(KIND_INSERT, 0, 32'h1111_1111);
      queue_request(KIND_INSERT, 2, 32'h2222_2222);
      queue_request(KIND_INSERT, 2047, 32'hFFFF_FFFF);
      queue_request(KIND_INSERT, 1, 32'hFFFF_FFFF);
      queue_request(KIND_INSERT, 2, 32'h0);
      queue_request(KIND_INSERT, 1, 32'h8000_0001);
      queue_request(KIND_INSERT, 4, 32'h5A5A_A5A5);
      queue_request(KIND_READ,   4, 32'h0);
      queue_request(KIND_READ,   5, 32'h0);
      queue_request(KIND_READ,   2047, 32'h0);
      queue_request(KIND_NEXT,   3, 32'h0);
      queue_request(KIND_NEXT,   4, 32'h0);
      queue_request(KIND_NEXT,   0, 32'h0);
      queue_request(KIND_PREV,   5, 32'h0);
      queue_request(KIND_PREV,   6, 32'h0);
      queue_request(KIND_LOCATE, 0, 32'h0);
      queue_request(KIND_LOCATE, 0, 32'h1234_5678);
      queue_request(KIND_UNUSED, 2047, 32'hFFFF_FFFF);
      queue_request(KIND_REMOVE, 5, 32'h0);
      queue_request(KIND_REMOVE, 2, 32'h0);
      queue_request(KIND_REMOVE, 3, 32'h0);
      queue_request(KIND_CLEAR,  0, 32'h0);

      for (n = 0; n < 220; n++) queue_random(40);

      // fill to a long list, after a full drain
      last_fill = $urandom;
      queue_request(KIND_INSERT, plan_count + 1, last_fill, 1'b1);
      while (plan_count < FILL_COUNT) begin
         last_fill = $urandom;
         queue_request(KIND_INSERT, plan_count + 1, last_fill);
      end
      queue_request(KIND_INSERT, plan_count + 2, 32'hDEAD_BEEF);
      queue_request(KIND_INSERT, 1, 32'hDEAD_BEEF);
      queue_request(KIND_READ,   plan_count, 32'h0);
      queue_request(KIND_NEXT,   plan_count - 1, 32'h0);
      queue_request(KIND_NEXT,   plan_count, 32'h0);
      queue_request(KIND_PREV,   plan_count + 1, 32'h0);
      queue_request(KIND_LOCATE, 0, last_fill);
      queue_request(KIND_LOCATE, 0, $urandom);
      queue_request(KIND_REMOVE, 1, 32'h0);
      queue_request(KIND_INSERT, 1, $urandom);
      queue_request(KIND_REMOVE, plan_count, 32'h0);
      queue_request(KIND_INSERT, plan_count, $urandom);
      for (n = 0; n < 20; n++) queue_random(2 * FILL_COUNT);
      queue_request(KIND_CLEAR, 0, 32'h0);

      for (n = 0; n < 60; n++) queue_random(40);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (list_requests.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (1100) @(posedge clock);
      if (expected_replies.size() != 0)
         note_mismatch("replies never seen", 32'(expected_replies.size()), 32'h0);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/pls_pkg.sv
hw/rtl/pls_ram.sv
hw/rtl/pls_ctrl.sv
hw/rtl/positional_list_store_core.sv
tb/sv/testbench.sv
